// ===== hdl/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam logic [7:0]  HDR_BYTE     = 8'hBB;
    localparam logic [7:0]  END_BYTE     = 8'h7E;
    localparam logic [15:0] MAXLEN_RESET = 16'd3072;
    localparam int          ADDR_W       = 3;
    localparam int          DATA_W       = 32;
    localparam logic [16:0] POS_PAYLOAD  = 17'd5;

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_FIELD   = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_GOOD    = 3'd3,
        EV_CSUM    = 3'd4,
        EV_NOEND   = 3'd5,
        EV_LONG    = 3'd6
    } t_event;

    typedef enum logic [0:0] {
        REG_MAXLEN = 1'b0,
        REG_NONE   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_type;
        logic [7:0]  frame_command;
        logic [15:0] payload_length;
    } t_result;

endpackage

// ===== hdl/lpfd_regs.sv =====
// ----------------------------------------------------------------------------
// lpfd_regs
// APB-style configuration register file holding the maximum payload length.
// ----------------------------------------------------------------------------
module lpfd_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpfd_pkg::ADDR_W-1:0] paddr,
    input  logic [lpfd_pkg::DATA_W-1:0] pwdata,
    output logic [lpfd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [15:0]                o_max_len
);
    import lpfd_pkg::*;

    logic [15:0] r_max_len;
    logic [15:0] n_max_len;
    t_reg_idx    reg_idx;
    logic        wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_max_len = r_max_len;
        if (wr_en && reg_idx == REG_MAXLEN) begin
            n_max_len = pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAXLEN_RESET;
        end else begin
            r_max_len <= n_max_len;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAXLEN: prdata = {{(DATA_W-16){1'b0}}, r_max_len};
            default:    prdata = '0;
        endcase
    end

    assign o_max_len = r_max_len;

endmodule

// ===== hdl/lpfd_parser.sv =====
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame state registers and per-byte classification.
// ----------------------------------------------------------------------------
module lpfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic [15:0]       i_max_len,
    output lpfd_pkg::t_result o_result
);
    import lpfd_pkg::*;

    logic        r_in_frame,  n_in_frame;
    logic [16:0] r_position,  n_position;
    logic [15:0] r_length,    n_length;
    logic [7:0]  r_sum,       n_sum;
    logic        r_mismatch,  n_mismatch;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_command,   n_command;

    t_event      ev;
    logic [15:0] pidx;
    logic [16:0] csum_pos;
    logic [16:0] pay_off;

    assign csum_pos = {1'b0, r_length} + POS_PAYLOAD;
    assign pay_off  = r_position - POS_PAYLOAD;

    always_comb begin
        n_in_frame = r_in_frame;
        n_position = r_position;
        n_length   = r_length;
        n_sum      = r_sum;
        n_mismatch = r_mismatch;
        n_type     = r_type;
        n_command  = r_command;
        ev         = EV_IGNORED;
        pidx       = '0;
        if (!r_in_frame) begin
            if (i_rx_byte == HDR_BYTE) begin
                n_in_frame = 1'b1;
                n_position = 17'd1;
                n_length   = '0;
                n_sum      = '0;
                n_mismatch = 1'b0;
                n_type     = '0;
                n_command  = '0;
                ev         = EV_FIELD;
            end
        end else begin
            if (r_position <= 17'd4) begin
                n_sum = r_sum + i_rx_byte;
                ev    = EV_FIELD;
                case (r_position[2:0])
                    3'd1:    n_type    = i_rx_byte;
                    3'd2:    n_command = i_rx_byte;
                    3'd3:    n_length  = {8'd0, i_rx_byte};
                    default: begin
                        n_length = {r_length[7:0], i_rx_byte};
                        if ({r_length[7:0], i_rx_byte} > i_max_len) begin
                            ev         = EV_LONG;
                            n_in_frame = 1'b0;
                        end
                    end
                endcase
            end else if (r_position < csum_pos) begin
                n_sum = r_sum + i_rx_byte;
                ev    = EV_PAYLOAD;
                pidx  = pay_off[15:0];
            end else if (r_position == csum_pos) begin
                n_mismatch = (i_rx_byte != r_sum);
                ev         = EV_FIELD;
            end else begin
                if (i_rx_byte != END_BYTE) begin
                    ev = EV_NOEND;
                end else if (r_mismatch) begin
                    ev = EV_CSUM;
                end else begin
                    ev = EV_GOOD;
                end
                n_in_frame = 1'b0;
            end
            n_position = n_in_frame ? r_position + 17'd1 : '0;
        end
    end

    always_comb begin
        o_result.event_res      = ev;
        o_result.data_byte      = i_rx_byte;
        o_result.payload_index  = pidx;
        o_result.frame_type     = n_type;
        o_result.frame_command  = n_command;
        o_result.payload_length = (n_in_frame && n_position <= 17'd4) ? 16'd0 : n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_position <= '0;
            r_length   <= '0;
            r_sum      <= '0;
            r_mismatch <= 1'b0;
            r_type     <= '0;
            r_command  <= '0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_position <= n_position;
            r_length   <= n_length;
            r_sum      <= n_sum;
            r_mismatch <= n_mismatch;
            r_type     <= n_type;
            r_command  <= n_command;
        end
    end

endmodule

// ===== hdl/lpfd_out_buf.sv =====
// ----------------------------------------------------------------------------
// lpfd_out_buf
// Two-entry result buffer separating the input and output handshakes.
// ----------------------------------------------------------------------------
module lpfd_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpfd_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output lpfd_pkg::t_result o_result
);
    import lpfd_pkg::*;

    t_result     r_buf [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count,  n_count;
    logic        pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign pop      = o_valid && !i_stall;
    assign o_result = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_result;
        end
    end

endmodule

// ===== hdl/length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Byte-wise parser for 0xBB..0x7E frames with 16-bit length and additive
// checksum; one classification event per received byte.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall | i_rx_byte
//   out     | output    | o_out_valid / i_out_stall | event, byte, index, type,
//           |           |                         | command, length
//   cfg     | input     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// One byte per cycle while the input is not stalled. The frame state updates at
// the accepting edge, where the result is written into the result buffer.
// A two-entry result buffer absorbs output stalls; input stalls only when
// both entries are held. Synchronous reset returns to header hunt with the
// maximum length at 3072.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_event_res,
    output logic [7:0]                  o_data_byte,
    output logic [15:0]                 o_payload_index,
    output logic [7:0]                  o_frame_type,
    output logic [7:0]                  o_frame_command,
    output logic [15:0]                 o_payload_length,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpfd_pkg::ADDR_W-1:0] paddr,
    input  logic [lpfd_pkg::DATA_W-1:0] pwdata,
    output logic [lpfd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lpfd_pkg::*;

    logic        max_len_sel;
    logic [15:0] max_len;
    logic        accept;
    logic        buf_full;
    t_result     parse_res;
    t_result     out_res;

    assign max_len_sel = 1'b1;
    assign o_in_stall  = buf_full;
    assign accept      = i_in_valid && !buf_full && max_len_sel;

    lpfd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    lpfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_max_len (max_len),
        .o_result  (parse_res)
    );

    lpfd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (parse_res),
        .o_full   (buf_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_res)
    );

    assign o_event_res      = out_res.event_res;
    assign o_data_byte      = out_res.data_byte;
    assign o_payload_index  = out_res.payload_index;
    assign o_frame_type     = out_res.frame_type;
    assign o_frame_command  = out_res.frame_command;
    assign o_payload_length = out_res.payload_length;

endmodule

// ===== dv/length_prefixed_frame_deframer_test.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_test
// Self-checking testbench for the length-prefixed frame deframer. A byte
// stream of well-formed frames with random content is mixed with checksum
// errors, missing end bytes, oversized lengths, cut frames and line noise.
// Every accepted byte is classified by an in-bench frame tracker, and each
// result transaction is compared with the oldest prediction. The maximum
// payload length is reprogrammed between phases, extremes included, while
// both handshake sides idle at varying rates.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfd_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SEGMENT_BYTES = 250;
    localparam int SEGMENTS      = 6;
    localparam int DIRECTED_N    = 29;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_END,
        FR_TOO_LONG,
        FR_CUT,
        FR_NOISE
    } t_frame_kind;

    // noise, zero-length good frame, oversized length, header byte inside
    // payload with a bad checksum, wrong end byte
    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_N] = '{
        8'h00, 8'hFF,
        HDR_BYTE, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, END_BYTE,
        HDR_BYTE, 8'hA5, 8'h5A, 8'hFF, 8'hFF,
        HDR_BYTE, 8'h12, 8'h34, 8'h00, 8'h01, HDR_BYTE, 8'h03, END_BYTE,
        HDR_BYTE, 8'h01, 8'h02, 8'h00, 8'h00, 8'h03, 8'h55
    };

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_rx_byte        = 8'h00;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [2:0]          o_event_res;
    logic [7:0]          o_data_byte;
    logic [15:0]         o_payload_index;
    logic [7:0]          o_frame_type;
    logic [7:0]          o_frame_command;
    logic [15:0]         o_payload_length;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [ADDR_W-1:0]   paddr            = '0;
    logic [DATA_W-1:0]   pwdata           = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int cycle_count   = 0;
    int segment_bytes = 0;

    class t_frame_scoreboard;
        t_result     expected_q[$];
        logic [15:0] max_len;
        bit          in_frame;
        logic [16:0] position;
        logic [15:0] length_value;
        logic [7:0]  running_sum;
        bit          sum_mismatch;
        logic [7:0]  type_hold;
        logic [7:0]  command_hold;
        int          errors;
        int          bytes_seen;
        int          event_count[8];

        function new();
            max_len      = MAXLEN_RESET;
            in_frame     = 1'b0;
            position     = '0;
            length_value = '0;
            running_sum  = '0;
            sum_mismatch = 1'b0;
            type_hold    = '0;
            command_hold = '0;
            errors       = 0;
            bytes_seen   = 0;
            foreach (event_count[i]) event_count[i] = 0;
        endfunction

        function void set_max_len(logic [31:0] value);
            max_len = value[15:0];
        endfunction

        function void note_byte(logic [7:0] b);
            t_result     r;
            logic [16:0] p;
            r.event_res     = EV_IGNORED;
            r.payload_index = '0;
            if (!in_frame) begin
                if (b == HDR_BYTE) begin
                    in_frame     = 1'b1;
                    position     = 17'd1;
                    length_value = '0;
                    running_sum  = '0;
                    sum_mismatch = 1'b0;
                    type_hold    = '0;
                    command_hold = '0;
                    r.event_res  = EV_FIELD;
                end
            end else begin
                p = position;
                if (p <= 17'd4) begin
                    running_sum = running_sum + b;
                    r.event_res = EV_FIELD;
                    case (p)
                        17'd1: type_hold = b;
                        17'd2: command_hold = b;
                        17'd3: length_value = {8'h00, b};
                        default: begin
                            length_value = {length_value[7:0], b};
                            if (length_value > max_len) begin
                                r.event_res = EV_LONG;
                                in_frame    = 1'b0;
                            end
                        end
                    endcase
                end else if (int'(p) < int'(length_value) + 5) begin
                    running_sum     = running_sum + b;
                    r.event_res     = EV_PAYLOAD;
                    r.payload_index = 16'(p - POS_PAYLOAD);
                end else if (int'(p) == int'(length_value) + 5) begin
                    sum_mismatch = (b != running_sum);
                    r.event_res  = EV_FIELD;
                end else begin
                    if (b != END_BYTE)
                        r.event_res = EV_NOEND;
                    else if (sum_mismatch)
                        r.event_res = EV_CSUM;
                    else
                        r.event_res = EV_GOOD;
                    in_frame = 1'b0;
                end
                position = in_frame ? p + 17'd1 : 17'd0;
            end
            r.data_byte      = b;
            r.frame_type     = type_hold;
            r.frame_command  = command_hold;
            r.payload_length = (in_frame && position <= 17'd4) ? 16'h0000 : length_value;
            expected_q.push_back(r);
            bytes_seen++;
        endfunction

        function void check_result(t_result seen);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result ev=%0d byte=%02h idx=%0d", $time,
                         seen.event_res, seen.data_byte, seen.payload_index);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (seen !== want) begin
                $display("%0t: mismatch expected ev=%0d byte=%02h idx=%0d type=%02h cmd=%02h len=%0d",
                         $time, want.event_res, want.data_byte, want.payload_index,
                         want.frame_type, want.frame_command, want.payload_length);
                $display("%0t:          actual   ev=%0d byte=%02h idx=%0d type=%02h cmd=%02h len=%0d",
                         $time, seen.event_res, seen.data_byte, seen.payload_index,
                         seen.frame_type, seen.frame_command, seen.payload_length);
                errors++;
            end
            if (!$isunknown(seen.event_res))
                event_count[seen.event_res]++;
        endfunction
    endclass

    t_frame_scoreboard sb = new();

    length_prefixed_frame_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_data_byte      (o_data_byte),
        .o_payload_index  (o_payload_index),
        .o_frame_type     (o_frame_type),
        .o_frame_command  (o_frame_command),
        .o_payload_length (o_payload_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
            $display("length_prefixed_frame_deframer regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.event_res      = t_event'(o_event_res);
            seen.data_byte      = o_data_byte;
            seen.payload_index  = o_payload_index;
            seen.frame_type     = o_frame_type;
            seen.frame_command  = o_frame_command;
            seen.payload_length = o_payload_length;
            sb.check_result(seen);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_byte(b);
        segment_bytes++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_MAXLEN)
            sb.set_max_len(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [7:0]  frame_q[$];
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] len;
        int          cap;
        int          cut;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            return;
        end
        cap = (sb.max_len > 16'd300) ? 300 : int'(sb.max_len);
        if (kind == FR_TOO_LONG)
            len = 16'($urandom_range(int'(sb.max_len) + 1, 65535));
        else if ($urandom_range(0, 7) == 0 && sb.max_len <= 16'd300)
            len = sb.max_len;
        else if ($urandom_range(0, 19) == 0)
            len = 16'($urandom_range(0, cap));
        else
            len = 16'($urandom_range(0, (cap < 12) ? cap : 12));
        frame_q.push_back(HDR_BYTE);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'($urandom));
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
        sum = frame_q[1] + frame_q[2] + frame_q[3] + frame_q[4];
        if (kind != FR_TOO_LONG) begin
            repeat (int'(len)) begin
                b = 8'($urandom);
                frame_q.push_back(b);
                sum = sum + b;
            end
            frame_q.push_back((kind == FR_BAD_SUM) ? sum + 8'($urandom_range(1, 255)) : sum);
            if (kind == FR_BAD_END) begin
                do b = 8'($urandom); while (b == END_BYTE);
                frame_q.push_back(b);
            end else begin
                frame_q.push_back(END_BYTE);
            end
        end
        cut = (kind == FR_CUT) ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
        for (int i = 0; i < cut; i++)
            send_byte(frame_q[i]);
    endtask

    initial begin
        t_frame_kind kind;
        int          pick;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        out_stall_pct = 48;
        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            case (seg)
                1: write_reg(REG_MAXLEN, {16'($urandom), 16'h0000});
                2: write_reg(REG_MAXLEN, 32'h0000_FFFF);
                3: write_reg(REG_MAXLEN, 32'($urandom_range(1, 40)));
                4: begin
                    write_reg(REG_MAXLEN, {16'($urandom), 16'($urandom_range(0, 300))});
                    write_reg(REG_NONE, 32'($urandom));
                end
                5: write_reg(REG_MAXLEN, 32'(MAXLEN_RESET));
                default: ;
            endcase
            send_idle_pct = (seg < 2) ? 27 : (seg < 4) ? 48 : 0;
            out_stall_pct = (seg < 2) ? 48 : (seg < 4) ? 27 : 0;
            segment_bytes = 0;
            while (segment_bytes < SEGMENT_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)      kind = FR_GOOD;
                else if (pick < 70) kind = FR_BAD_SUM;
                else if (pick < 78) kind = FR_BAD_END;
                else if (pick < 86) kind = (sb.max_len == 16'hFFFF) ? FR_GOOD : FR_TOO_LONG;
                else if (pick < 92) kind = FR_CUT;
                else                kind = FR_NOISE;
                send_frame(kind);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d bytes over %0d length limits: %0d good frames, %0d checksum errors,",
                 sb.bytes_seen, SEGMENTS, sb.event_count[EV_GOOD], sb.event_count[EV_CSUM]);
        $display("%0d missing end bytes, %0d oversized frames, %0d payload bytes forwarded.",
                 sb.event_count[EV_NOEND], sb.event_count[EV_LONG], sb.event_count[EV_PAYLOAD]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("length_prefixed_frame_deframer regression: pass");
        end else begin
            $display("%0d errors, %0d results outstanding", sb.errors, sb.expected_q.size());
            $display("length_prefixed_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lpfd_pkg.sv
hdl/lpfd_regs.sv
hdl/lpfd_parser.sv
hdl/lpfd_out_buf.sv
hdl/length_prefixed_frame_deframer.sv
dv/length_prefixed_frame_deframer_test.sv
